FILE: rtl/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force package
// Payload types, register and class codes, and the fixed-point helpers
// shared by the pair force pipeline and its arithmetic units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_CE_PROT  = 3'd0;
	localparam logic [2:0] REG_RE_PROT  = 3'd1;
	localparam logic [2:0] REG_CE_NUC   = 3'd2;
	localparam logic [2:0] REG_RE_NUC   = 3'd3;
	localparam logic [2:0] REG_CE_IFC   = 3'd4;
	localparam logic [2:0] REG_RE_IFC   = 3'd5;
	localparam logic [2:0] REG_NB_SCALE = 3'd6;
	localparam logic [2:0] REG_CUTOFF   = 3'd7;

	// Region selector codes.
	localparam logic [1:0] REGION_PROT = 2'd0;
	localparam logic [1:0] REGION_NUC  = 2'd1;
	localparam logic [1:0] REGION_IFC  = 2'd2;
	localparam logic [1:0] REGION_NONE = 2'd3;

	// Energy class codes.
	localparam logic [1:0] CLS_CONTACT = 2'd0;
	localparam logic [1:0] CLS_BONDED  = 2'd1;
	localparam logic [1:0] CLS_REPULSE = 2'd2;

	// Fixed-point constants; internal magnitudes are Q.24 capped at 2^63-1.
	localparam logic [62:0] CAP       = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] ONE_Q24   = 63'h100_0000;
	localparam logic [62:0] TWO_Q24   = 63'h200_0000;
	localparam logic [62:0] CAP_DIV6  = CAP / 63'd6;
	localparam logic [62:0] CAP_DIV12 = CAP / 63'd12;
	localparam logic [23:0] CFG_RESET = 24'h01_0000;

	typedef struct packed {
		logic        [1:0]  req_type;
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
		logic        [31:0] native_dist_sq;
		logic               is_contact;
		logic        [9:0]  seq_gap;
	} pair_in_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] pair_energy;
		logic        [1:0]  energy_class;
		logic               in_range;
		logic               has_force;
	} pair_out_t;

	// Per-pair context that travels down the pipeline next to the data.
	typedef struct packed {
		logic [1:0]        region;
		logic [1:0]        cls;
		logic [2:0]        neg;
		logic [2:0][31:0]  mag;
		logic [31:0]       nat;
		logic [63:0]       r2;
		logic              in_range;
		logic              has_force;
		logic [39:0]       rp;
		logic [62:0]       p6;
		logic [62:0]       m3;
		logic [62:0]       emag;
		logic              eneg;
		logic [62:0]       cmag;
		logic              cneg;
	} ctx_t;

	// Full product shifted down by 24, saturated at the cap.
	function automatic logic [62:0] mulq_sat(input logic [127:0] p);
		if (p[127:87] != '0)
			return CAP;
		return p[86:24];
	endfunction

	// Saturating multiply by six.
	function automatic logic [62:0] mul6(input logic [62:0] a);
		logic [65:0] t;
		t = ({3'd0, a} << 1) + ({3'd0, a} << 2);
		if (a > CAP_DIV6)
			return CAP;
		return t[62:0];
	endfunction

	// Saturating multiply by twelve.
	function automatic logic [62:0] mul12(input logic [62:0] a);
		logic [66:0] t;
		t = ({4'd0, a} << 2) + ({4'd0, a} << 3);
		if (a > CAP_DIV12)
			return CAP;
		return t[62:0];
	endfunction

	// Sign a magnitude and clamp it to 48-bit two's complement.
	function automatic logic [47:0] pack48(input logic neg, input logic [63:0] mag);
		logic [47:0] m;
		if (neg) begin
			if (mag > 64'h8000_0000_0000)
				m = 48'h8000_0000_0000;
			else
				m = mag[47:0];
			return 48'd0 - m;
		end
		if (mag > 64'h7FFF_FFFF_FFFF)
			return 48'h7FFF_FFFF_FFFF;
		return mag[47:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ljpf_mul.sv
// ----------------------------------------------------------------------------
// Pipelined wide multiplier
// Multiplies LANES pairs of 64-bit unsigned operands to full 128-bit
// products over two stages: 32x32 partial products, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ljpf_mul
	import ljpf_pkg::*;
#(
	parameter int unsigned LANES = 1,
	parameter int unsigned SW    = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [LANES-1:0][63:0]      a,
	input  wire logic [LANES-1:0][63:0]      b,
	input  wire logic [SW-1:0]               side,
	output logic                             out_valid,
	output logic      [LANES-1:0][127:0]     prod,
	output logic      [SW-1:0]               side_out
);

	logic [LANES-1:0][3:0][63:0] pp_s1;
	logic [LANES-1:0][127:0]     prod_s2;
	logic [SW-1:0]               side_s1;
	logic [SW-1:0]               side_s2;
	logic                        v_s1;
	logic                        v_s2;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage one forms the four partial products, stage two adds them.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				pp_s1[l][0] <= 64'(a[l][31:0])  * 64'(b[l][31:0]);
				pp_s1[l][1] <= 64'(a[l][31:0])  * 64'(b[l][63:32]);
				pp_s1[l][2] <= 64'(a[l][63:32]) * 64'(b[l][31:0]);
				pp_s1[l][3] <= 64'(a[l][63:32]) * 64'(b[l][63:32]);
				prod_s2[l]  <= {pp_s1[l][3], pp_s1[l][0]}
					+ {32'd0, pp_s1[l][1], 32'd0}
					+ {32'd0, pp_s1[l][2], 32'd0};
			end
			side_s1 <= side;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;
	assign side_out  = side_s2;

endmodule

`default_nettype wire

FILE: rtl/ljpf_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides LANES dividends by one shared 64-bit divisor, one quotient bit
// per stage. The dividend is a starting remainder plus QW low bits; sat
// flags a quotient that does not fit in QW bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ljpf_div
	import ljpf_pkg::*;
#(
	parameter int unsigned LANES = 1,
	parameter int unsigned QW    = 32,
	parameter int unsigned SW    = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [LANES-1:0][63:0]     num_hi,
	input  wire logic [LANES-1:0][QW-1:0]   num_lo,
	input  wire logic [63:0]                den,
	input  wire logic [SW-1:0]              side,
	output logic                            out_valid,
	output logic      [LANES-1:0][QW-1:0]   quo,
	output logic      [LANES-1:0]           sat,
	output logic      [SW-1:0]              side_out
);

	logic [LANES-1:0][63:0]   rem_s  [QW+1];
	logic [LANES-1:0][QW-1:0] lo_s   [QW+1];
	logic [LANES-1:0][QW-1:0] q_s    [QW+1];
	logic [LANES-1:0]         sat_s  [QW+1];
	logic [63:0]              den_s  [QW+1];
	logic [SW-1:0]            side_s [QW+1];
	logic [QW:0]              v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-1:0], in_valid};
		end
	end

	// Entry stage: a starting remainder at or above the divisor overflows.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= num_hi[l];
				lo_s[0][l]  <= num_lo[l];
				q_s[0][l]   <= '0;
				sat_s[0][l] <= (num_hi[l] >= den);
			end
			den_s[0]  <= den;
			side_s[0] <= side;
		end
	end

	// One trial subtraction per stage.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [LANES-1:0][63:0] rem_nx;
		logic [LANES-1:0]       bit_nx;

		always_comb begin
			logic [64:0] trial;
			logic [64:0] diff;
			for (int l = 0; l < LANES; l++) begin
				trial      = {rem_s[k][l], lo_s[k][l][QW-1]};
				diff       = trial - {1'b0, den_s[k]};
				bit_nx[l]  = (trial >= {1'b0, den_s[k]});
				rem_nx[l]  = bit_nx[l] ? diff[63:0] : trial[63:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= rem_nx[l];
					lo_s[k+1][l]  <= {lo_s[k][l][QW-2:0], 1'b0};
					q_s[k+1][l]   <= {q_s[k][l][QW-2:0], bit_nx[l]};
					sat_s[k+1][l] <= sat_s[k][l];
				end
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign sat       = sat_s[QW];
	assign side_out  = side_s[QW];

endmodule

`default_nettype wire

FILE: rtl/lj_pair_force_top.sv
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair force pipeline
// Takes one bead pair per clock while the output is not stalled and returns
// its energy, class and force vector in order. The pipeline is built around
// two bit-serial dividers: 33 stages forming the distance ratio and 49
// stages dividing the force numerator by the squared distance; six
// two-stage multipliers and eight stage registers make up the rest.
// Back-pressure on the output stalls the whole pipeline, so input is taken
// whenever the output register is empty or being drained. Configuration is
// written through its own port, takes effect at once and must be changed
// only while no pair is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lj_pair_force_top
	import ljpf_pkg::*;
#(
	parameter logic [31:0] MAX_RATIO_Q16 = 32'd6553600
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pair_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output pair_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned CW = $bits(ctx_t);

	// Configuration registers.
	logic [23:0] ce_prot_q, re_prot_q, ce_nuc_q, re_nuc_q, ce_ifc_q, re_ifc_q;
	logic [23:0] nb_scale_q;
	logic [31:0] cutoff_q;
	logic [39:0] nb_prot_q, nb_nuc_q, nb_ifc_q;

	logic adv;

	// Pipeline registers and unit outputs.
	ctx_t                ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [62:0]         sq_s4;
	ctx_t                ctx_sq, ctx_dv, ctx_ma, ctx_mb, ctx_mc, ctx_md, ctx_me, ctx_fd;
	logic                v_sq, v_dv, v_ma, v_mb, v_mc, v_md, v_me, v_fd;
	logic [2:0][127:0]   prod_sq, prod_me;
	logic [0:0][127:0]   prod_ma, prod_mb, prod_mc;
	logic [1:0][127:0]   prod_md;
	logic [0:0][31:0]    dv_quo;
	logic [0:0]          dv_sat;
	logic [2:0][47:0]    fd_quo;
	logic [2:0]          fd_sat;
	pair_out_t           out_q;
	logic                out_valid_q;

	// Combinational stage inputs.
	ctx_t                ctx_in, ctx_r2, ctx_rt, ctx_en, ctx_pw, ctx_sc;
	logic [2:0][63:0]    sq_a, me_a, me_b, fd_hi;
	logic [2:0][47:0]    fd_lo;
	logic [1:0][63:0]    md_a, md_b;
	logic [39:0]         x_sel;
	logic [31:0]         ratio;
	logic [62:0]         c4;
	pair_out_t           out_d;

	// The whole pipeline advances unless a finished result waits unaccepted.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce_prot_q  <= CFG_RESET;
			re_prot_q  <= CFG_RESET;
			ce_nuc_q   <= CFG_RESET;
			re_nuc_q   <= CFG_RESET;
			ce_ifc_q   <= CFG_RESET;
			re_ifc_q   <= CFG_RESET;
			nb_scale_q <= CFG_RESET;
			cutoff_q   <= {8'd0, CFG_RESET};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CE_PROT:  ce_prot_q  <= cfg_data[23:0];
				REG_RE_PROT:  re_prot_q  <= cfg_data[23:0];
				REG_CE_NUC:   ce_nuc_q   <= cfg_data[23:0];
				REG_RE_NUC:   re_nuc_q   <= cfg_data[23:0];
				REG_CE_IFC:   ce_ifc_q   <= cfg_data[23:0];
				REG_RE_IFC:   re_ifc_q   <= cfg_data[23:0];
				REG_NB_SCALE: nb_scale_q <= cfg_data[23:0];
				REG_CUTOFF:   cutoff_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bonded repulsion per region, neighbour scale times repulsion in Q.24.
	always_ff @(posedge clk) begin
		nb_prot_q <= 40'((48'(nb_scale_q) * 48'(re_prot_q)) >> 8);
		nb_nuc_q  <= 40'((48'(nb_scale_q) * 48'(re_nuc_q)) >> 8);
		nb_ifc_q  <= 40'((48'(nb_scale_q) * 48'(re_ifc_q)) >> 8);
	end

	// Input stage: split the displacement into sign and magnitude, classify.
	always_comb begin
		logic [31:0] raw;
		ctx_in        = '0;
		ctx_in.region = in_data.req_type;
		ctx_in.nat    = in_data.native_dist_sq;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0:       raw = in_data.disp_x;
				1:       raw = in_data.disp_y;
				default: raw = in_data.disp_z;
			endcase
			ctx_in.neg[k] = raw[31];
			ctx_in.mag[k] = raw[31] ? (32'd0 - raw) : raw;
		end
		case (in_data.req_type)
			REGION_IFC:
				ctx_in.cls = in_data.is_contact ? CLS_CONTACT : CLS_REPULSE;
			REGION_PROT, REGION_NUC: begin
				if (in_data.is_contact && in_data.seq_gap > 10'd2)
					ctx_in.cls = CLS_CONTACT;
				else if (in_data.is_contact && in_data.seq_gap == 10'd1)
					ctx_in.cls = CLS_BONDED;
				else
					ctx_in.cls = CLS_REPULSE;
			end
			default: ctx_in.cls = CLS_REPULSE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_sq;
			v_s3 <= v_dv;
			v_s4 <= v_ma;
			v_s5 <= v_mb;
			v_s6 <= v_mc;
			v_s7 <= v_md;
			out_valid_q <= v_fd;
		end
	end

	// Squares of the three displacement magnitudes.
	always_comb begin
		for (int k = 0; k < 3; k++)
			sq_a[k] = {32'd0, ctx_s1.mag[k]};
	end

	ljpf_mul #(.LANES(3), .SW(CW)) u_mul_sq (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.a(sq_a), .b(sq_a), .side(ctx_s1),
		.out_valid(v_sq), .prod(prod_sq), .side_out(ctx_sq)
	);

	// Squared distance.
	always_comb begin
		ctx_r2    = ctx_sq;
		ctx_r2.r2 = prod_sq[0][63:0] + prod_sq[1][63:0] + prod_sq[2][63:0];
	end

	// Ratio of native to current squared distance in Q16.16.
	ljpf_div #(.LANES(1), .QW(32), .SW(CW)) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s2),
		.num_hi({32'd0, ctx_s2.nat}), .num_lo(32'd0), .den(ctx_s2.r2),
		.side(ctx_s2),
		.out_valid(v_dv), .quo(dv_quo), .sat(dv_sat), .side_out(ctx_dv)
	);

	// Cutoff and force limit decisions.
	always_comb begin
		ratio            = dv_sat[0] ? 32'hFFFF_FFFF : dv_quo[0];
		ctx_rt           = ctx_dv;
		ctx_rt.in_range  = (ctx_dv.region != REGION_NONE) && (ratio >= cutoff_q);
		ctx_rt.has_force = ctx_rt.in_range && (ctx_dv.r2 != 64'd0)
			&& (ratio <= MAX_RATIO_Q16);
		ctx_rt.rp        = {ratio, 8'd0};
	end

	// Ratio squared.
	ljpf_mul #(.LANES(1), .SW(CW)) u_mul_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s3),
		.a({24'd0, ctx_s3.rp}), .b({24'd0, ctx_s3.rp}), .side(ctx_s3),
		.out_valid(v_ma), .prod(prod_ma), .side_out(ctx_ma)
	);

	// Ratio cubed, that is the sixth power of the distance ratio.
	ljpf_mul #(.LANES(1), .SW(CW)) u_mul_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.a({1'b0, sq_s4}), .b({24'd0, ctx_s4.rp}), .side(ctx_s4),
		.out_valid(v_mb), .prod(prod_mb), .side_out(ctx_mb)
	);

	// Energy scale chosen by region and class.
	always_comb begin
		logic [23:0] ce;
		logic [23:0] re;
		logic [39:0] nb;
		case (ctx_s5.region)
			REGION_PROT: begin
				ce = ce_prot_q;
				re = re_prot_q;
				nb = nb_prot_q;
			end
			REGION_NUC: begin
				ce = ce_nuc_q;
				re = re_nuc_q;
				nb = nb_nuc_q;
			end
			REGION_IFC: begin
				ce = ce_ifc_q;
				re = re_ifc_q;
				nb = nb_ifc_q;
			end
			default: begin
				ce = '0;
				re = '0;
				nb = '0;
			end
		endcase
		case (ctx_s5.cls)
			CLS_CONTACT: x_sel = {8'd0, ce, 8'd0};
			CLS_BONDED:  x_sel = nb;
			default:     x_sel = {8'd0, re, 8'd0};
		endcase
	end

	ljpf_mul #(.LANES(1), .SW(CW)) u_mul_c (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s5),
		.a({24'd0, x_sel}), .b({1'b0, ctx_s5.p6}), .side(ctx_s5),
		.out_valid(v_mc), .prod(prod_mc), .side_out(ctx_mc)
	);

	// Contact well: scale times distance from two and from one.
	always_comb begin
		md_a[0] = {1'b0, ctx_s6.m3};
		md_a[1] = {1'b0, ctx_s6.m3};
		md_b[0] = {1'b0, (ctx_s6.p6 >= TWO_Q24) ? (ctx_s6.p6 - TWO_Q24)
			: (TWO_Q24 - ctx_s6.p6)};
		md_b[1] = {1'b0, (ctx_s6.p6 >= ONE_Q24) ? (ctx_s6.p6 - ONE_Q24)
			: (ONE_Q24 - ctx_s6.p6)};
	end

	ljpf_mul #(.LANES(2), .SW(CW)) u_mul_d (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.a(md_a), .b(md_b), .side(ctx_s6),
		.out_valid(v_md), .prod(prod_md), .side_out(ctx_md)
	);

	// Energy magnitude and radial force coefficient with their signs.
	always_comb begin
		ctx_en = ctx_md;
		c4     = mulq_sat(prod_md[1]);
		if (ctx_md.cls == CLS_CONTACT) begin
			ctx_en.emag = mulq_sat(prod_md[0]);
			ctx_en.eneg = (ctx_md.p6 < TWO_Q24);
			ctx_en.cmag = mul12(c4);
			ctx_en.cneg = (ctx_md.p6 < ONE_Q24);
		end else begin
			ctx_en.emag = ctx_md.m3;
			ctx_en.eneg = 1'b0;
			ctx_en.cmag = mul6(ctx_md.m3);
			ctx_en.cneg = 1'b0;
		end
	end

	// Sixth power and scaled power taken from their product units.
	always_comb begin
		ctx_pw    = ctx_mb;
		ctx_pw.p6 = mulq_sat(prod_mb[0]);
		ctx_sc    = ctx_mc;
		ctx_sc.m3 = mulq_sat(prod_mc[0]);
	end

	// Stage registers between the units.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1    <= ctx_in;
			ctx_s2    <= ctx_r2;
			ctx_s3    <= ctx_rt;
			ctx_s4    <= ctx_ma;
			sq_s4     <= mulq_sat(prod_ma[0]);
			ctx_s5    <= ctx_pw;
			ctx_s6    <= ctx_sc;
			ctx_s7    <= ctx_en;
			out_q     <= out_d;
		end
	end

	// Force numerators: displacement magnitude times coefficient.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			me_a[k] = {32'd0, ctx_s7.mag[k]};
			me_b[k] = {1'b0, ctx_s7.cmag};
		end
	end

	ljpf_mul #(.LANES(3), .SW(CW)) u_mul_e (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s7),
		.a(me_a), .b(me_b), .side(ctx_s7),
		.out_valid(v_me), .prod(prod_me), .side_out(ctx_me)
	);

	// Numerator shifted up by 16 bits, split into remainder and low bits.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fd_hi[k] = prod_me[k][95:32];
			fd_lo[k] = {prod_me[k][31:0], 16'd0};
		end
	end

	ljpf_div #(.LANES(3), .QW(48), .SW(CW)) u_div_force (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_me),
		.num_hi(fd_hi), .num_lo(fd_lo), .den(ctx_me.r2), .side(ctx_me),
		.out_valid(v_fd), .quo(fd_quo), .sat(fd_sat), .side_out(ctx_fd)
	);

	// Result assembly with output saturation.
	always_comb begin
		logic [2:0][47:0] fv;
		for (int k = 0; k < 3; k++) begin
			fv[k] = ctx_fd.has_force
				? pack48(ctx_fd.neg[k] ^ ctx_fd.cneg,
					fd_sat[k] ? 64'hFFFF_FFFF_FFFF_FFFF : {16'd0, fd_quo[k]})
				: 48'd0;
		end
		out_d.force_x      = fv[0];
		out_d.force_y      = fv[1];
		out_d.force_z      = fv[2];
		out_d.pair_energy  = ctx_fd.in_range ? pack48(ctx_fd.eneg, {1'b0, ctx_fd.emag})
			: 48'd0;
		out_d.energy_class = ctx_fd.cls;
		out_d.in_range     = ctx_fd.in_range;
		out_d.has_force    = ctx_fd.has_force;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/ljpf_checker.sv
// ----------------------------------------------------------------------------
// Pair force port checker
// Watches the ports of the pair force pipeline for stall behavior and for
// consistency between the range, force and energy fields of each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ljpf_checker
	import ljpf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire pair_out_t out_data
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An empty output register never blocks the input.
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A dropped pair carries neither energy nor force.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_range |->
			out_data.pair_energy == 48'd0 && !out_data.has_force)
		else $error("dropped pair has energy or force");

	// A suppressed force is exactly zero.
	a_force_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_force |->
			out_data.force_x == 48'd0 && out_data.force_y == 48'd0
			&& out_data.force_z == 48'd0)
		else $error("suppressed force is not zero");

endmodule

bind lj_pair_force_top ljpf_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

`default_nettype wire
